// ===== rtl/core/frx_pkg.sv =====
`default_nettype none

package frx_pkg;

  // Default payload buffer depth.
  localparam int unsigned MaxPayloadDefault = 64;

  // Fixed field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 7;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CrcW    = 16;

  // Register reset values.
  localparam logic [ByteW-1:0] SyncReset    = 8'hAA;
  localparam logic [ByteW-1:0] CmdTypeReset = 8'h01;
  localparam logic [LenW-1:0]  LimitReset   = 7'd64;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
  localparam logic [CrcW-1:0] CrcMsb  = 16'h8000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC     = 2'd0,
    CFG_CMD_TYPE = 2'd1,
    CFG_LIMIT    = 2'd2
  } cfg_idx_e;

  // Result kinds.
  localparam logic KindGood = 1'b0;
  localparam logic KindNak  = 1'b1;

  // Receiver phases plus the result burst.
  typedef enum logic [3:0] {
    ST_HUNT,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_TYPE,
    ST_SEQ,
    ST_DATA,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             resync;
  } frx_in_t;

  typedef struct packed {
    logic              kind;
    logic [ByteW-1:0]  frame_type;
    logic [ByteW-1:0]  frame_seq;
    logic [LenW-1:0]   frame_length;
    logic [IndexW-1:0] byte_index;
    logic [ByteW-1:0]  data_byte;
    logic              last;
    logic [ByteW-1:0]  command_seq;
  } frx_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_crc;
    logic clr_count;
    logic ld_len_lo;
    logic ld_len_hi;
    logic ld_type;
    logic ld_seq;
    logic ld_data;
    logic ld_crc_lo;
    logic check;
    logic emit;
  } frx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sync_hit;
    logic len_bad;
    logic len_zero;
    logic data_done;
    logic emit_last;
    logic out_free;
  } frx_sts_t;

  // One byte of CRC-16-CCITT, MSB first.
  function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != '0) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/framed_packet_receiver_crc16.sv =====
// Framed packet receiver with CRC-16-CCITT check.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one received byte per
// item; a set resync bit drops the byte and returns the receiver to sync hunt.
// Frames are sync, length (LE16), type, sequence, payload, CRC (LE16).
// Result channel (out_valid_o/out_ready_i/out_data_o) delivers one item per
// payload byte on a good CRC, one item for an empty payload, or one NAK item
// on a CRC mismatch.
// After the final CRC byte is taken, the controller enters the burst state and
// the first result is then loaded into the output register; the rest follow
// one per cycle while the output register is free, paced by the registered read
// port of the payload buffer; input is held off during the burst.
// Once the last result sits in the output register, input is taken again.
// A stalled receiver freezes the burst; the output register holds its item.
// Reset is asynchronous: the receiver hunts for sync, configuration returns
// to sync 0xAA, command type 1 and length limit 64, and the buffer content
// is undefined. Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i.
`default_nettype none

module framed_packet_receiver_crc16 #(
  parameter int unsigned MaxPayloadBytes = frx_pkg::MaxPayloadDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [frx_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [frx_pkg::ByteW-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire frx_pkg::frx_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output frx_pkg::frx_out_t                out_data_o
);
  import frx_pkg::*;

  frx_cmd_t cmd;
  frx_sts_t sts;

  // Frame controller.
  frx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .resync_i   (in_data_i.resync),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Header, CRC, payload buffer and output register.
  frx_dp #(
    .MaxPayloadBytes (MaxPayloadBytes)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (in_data_i.rx_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // A result item is never loaded over one still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result item overwritten in output register");

  // The CRC check starts a burst that holds off input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.check |=> !in_ready_o)
    else $error("input taken during result burst");

  // Loading the final item of a run releases the input channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.emit_last) |=> (in_ready_o && out_valid_o && out_data_o.last))
    else $error("burst did not end on its final item");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/frx_ctrl.sv =====
`default_nettype none

module frx_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              resync_i,
  output logic                   in_ready_o,
  input  wire frx_pkg::frx_sts_t sts_i,
  output frx_pkg::frx_cmd_t      cmd_o
);
  import frx_pkg::*;

  state_e state_q, state_d;
  logic   acc;

  // Input bytes are taken in every phase except during a result burst.
  assign in_ready_o = (state_q != ST_EMIT);
  assign acc        = in_valid_i && in_ready_o;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (acc && resync_i) begin
      cmd_o.clr_count = 1'b1;
      state_d         = ST_HUNT;
    end else begin
      case (state_q)
        ST_HUNT: begin
          if (acc && sts_i.sync_hit) begin
            cmd_o.start_crc = 1'b1;
            cmd_o.clr_count = 1'b1;
            state_d         = ST_LEN_LO;
          end
        end
        ST_LEN_LO: begin
          if (acc) begin
            cmd_o.ld_len_lo = 1'b1;
            state_d         = ST_LEN_HI;
          end
        end
        ST_LEN_HI: begin
          if (acc) begin
            cmd_o.ld_len_hi = 1'b1;
            state_d         = sts_i.len_bad ? ST_HUNT : ST_TYPE;
          end
        end
        ST_TYPE: begin
          if (acc) begin
            cmd_o.ld_type = 1'b1;
            state_d       = ST_SEQ;
          end
        end
        ST_SEQ: begin
          if (acc) begin
            cmd_o.ld_seq = 1'b1;
            state_d      = sts_i.len_zero ? ST_CRC_LO : ST_DATA;
          end
        end
        ST_DATA: begin
          if (acc) begin
            cmd_o.ld_data = 1'b1;
            if (sts_i.data_done) begin
              state_d = ST_CRC_LO;
            end
          end
        end
        ST_CRC_LO: begin
          if (acc) begin
            cmd_o.ld_crc_lo = 1'b1;
            state_d         = ST_CRC_HI;
          end
        end
        ST_CRC_HI: begin
          if (acc) begin
            cmd_o.check = 1'b1;
            state_d     = ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            if (sts_i.emit_last) begin
              state_d = ST_HUNT;
            end
          end
        end
        default: begin
          state_d = ST_HUNT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frx_dp.sv =====
`default_nettype none

module frx_dp #(
  parameter int unsigned MaxPayloadBytes = frx_pkg::MaxPayloadDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [frx_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [frx_pkg::ByteW-1:0]   cfg_wdata_i,
  input  wire logic [frx_pkg::ByteW-1:0]   rx_byte_i,
  input  wire frx_pkg::frx_cmd_t           cmd_i,
  output frx_pkg::frx_sts_t                sts_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output frx_pkg::frx_out_t                out_data_o
);
  import frx_pkg::*;

  localparam int unsigned AddrW = (MaxPayloadBytes > 1) ? $clog2(MaxPayloadBytes) : 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxPayloadBytes);

  // Configuration registers.
  logic [ByteW-1:0] sync_q, cmd_type_q;
  logic [LenW-1:0]  limit_q;

  // Frame registers.
  logic [ByteW-1:0] len_lo_q, type_q, seq_q, crc_lo_q, cmd_seq_q;
  logic [LenW-1:0]  length_q, count_q;
  logic [CrcW-1:0]  crc_q;
  logic             nak_q;
  logic [AddrW-1:0] idx_q, idx_d, rd_addr;

  // Payload buffer and its registered read port.
  logic [ByteW-1:0] mem_q [MaxPayloadBytes];
  logic [ByteW-1:0] rd_data_q;

  // Output register.
  logic     out_valid_q;
  frx_out_t out_q, out_d;

  logic [LenW-1:0] limit_eff;
  logic [LenW:0]   count_inc;
  logic            crc_ok;

  assign limit_eff = (limit_q > MaxLen) ? MaxLen : limit_q;
  assign count_inc = {1'b0, count_q} + (LenW+1)'(1);
  assign crc_ok    = ({rx_byte_i, crc_lo_q} == crc_q);

  // Status for the controller.
  always_comb begin
    sts_o.sync_hit  = (rx_byte_i == sync_q);
    sts_o.len_bad   = (rx_byte_i != '0) || (len_lo_q > {1'b0, limit_eff});
    sts_o.len_zero  = (length_q == '0);
    sts_o.data_done = (count_inc >= {1'b0, length_q});
    sts_o.emit_last = nak_q || (length_q == '0) || (LenW'(idx_q) == length_q - LenW'(1));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q     <= SyncReset;
      cmd_type_q <= CmdTypeReset;
      limit_q    <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC:     sync_q     <= cfg_wdata_i;
        CFG_CMD_TYPE: cmd_type_q <= cfg_wdata_i;
        CFG_LIMIT:    limit_q    <= cfg_wdata_i[LenW-1:0];
        default:      ;
      endcase
    end
  end

  // Header fields, payload count, running CRC and verdict.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_lo_q  <= '0;
      length_q  <= '0;
      type_q    <= '0;
      seq_q     <= '0;
      crc_lo_q  <= '0;
      count_q   <= '0;
      crc_q     <= CrcInit;
      nak_q     <= 1'b0;
      cmd_seq_q <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.clr_count) count_q <= '0;
      if (cmd_i.start_crc) crc_q <= CrcInit;
      if (cmd_i.ld_len_lo) len_lo_q <= rx_byte_i;
      if (cmd_i.ld_len_hi) length_q <= len_lo_q[LenW-1:0];
      if (cmd_i.ld_type) begin
        type_q <= rx_byte_i;
        crc_q  <= crc_feed(crc_q, rx_byte_i);
      end
      if (cmd_i.ld_seq) begin
        seq_q <= rx_byte_i;
        crc_q <= crc_feed(crc_q, rx_byte_i);
      end
      if (cmd_i.ld_data) begin
        crc_q   <= crc_feed(crc_q, rx_byte_i);
        count_q <= count_inc[LenW-1:0];
      end
      if (cmd_i.ld_crc_lo) crc_lo_q <= rx_byte_i;
      if (cmd_i.check) begin
        nak_q <= !crc_ok;
        if (crc_ok && (type_q == cmd_type_q)) begin
          cmd_seq_q <= seq_q;
        end
      end
      idx_q <= idx_d;
    end
  end

  // Burst index; the read address runs one item ahead of the output.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.check) begin
      idx_d = '0;
    end else if (cmd_i.emit) begin
      idx_d = idx_q + AddrW'(1);
    end
    rd_addr = idx_d;
  end

  // Payload buffer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_data) begin
      mem_q[count_q[AddrW-1:0]] <= rx_byte_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Next result item.
  always_comb begin
    out_d.kind         = nak_q ? KindNak : KindGood;
    out_d.frame_type   = type_q;
    out_d.frame_seq    = seq_q;
    out_d.frame_length = length_q;
    out_d.byte_index   = IndexW'(idx_q);
    out_d.data_byte    = (nak_q || (length_q == '0)) ? '0 : rd_data_q;
    out_d.last         = sts_o.emit_last;
    out_d.command_seq  = cmd_seq_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sim/framed_packet_receiver_crc16_tb.sv =====
`timescale 1ns / 100ps

module framed_packet_receiver_crc16_tb;
  import frx_pkg::*;

  localparam int unsigned BufDepth = MaxPayloadDefault;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned DrainLimit = 5000;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_NONE,
    ROW_ONE
  } row_mode_e;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             rs;
    row_mode_e        mode;
    frx_out_t         want;
  } dir_row_t;

  // NAK for an empty frame of type 0 and sequence 0 straight after reset.
  localparam frx_out_t NakEmpty = '{
    kind: KindNak, frame_type: 8'h00, frame_seq: 8'h00, frame_length: 7'd0,
    byte_index: 6'd0, data_byte: 8'h00, last: 1'b1, command_seq: 8'h00
  };

  // Directed bytes: resync, oversize lengths, a bad and a good empty frame.
  localparam dir_row_t DirRows [25] = '{
    '{8'h00, 1'b1, ROW_NONE, '0},   // resync right out of reset
    '{8'hFF, 1'b0, ROW_NONE, '0},   // not the sync byte
    '{8'hAA, 1'b0, ROW_NONE, '0},   // sync
    '{8'hFF, 1'b0, ROW_NONE, '0},
    '{8'hFF, 1'b0, ROW_NONE, '0},   // length 0xFFFF drops back to hunting
    '{8'hAA, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},   // type
    '{8'h00, 1'b0, ROW_NONE, '0},   // sequence
    '{8'hFF, 1'b0, ROW_NONE, '0},
    '{8'hFF, 1'b0, ROW_ONE, NakEmpty}, // wrong CRC
    '{8'hAA, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},
    '{8'h0F, 1'b0, ROW_NONE, '0},
    '{8'h1D, 1'b0, ROW_MODEL, '0},  // matching CRC of an empty frame
    '{8'hAA, 1'b0, ROW_NONE, '0},
    '{8'h41, 1'b0, ROW_NONE, '0},
    '{8'h00, 1'b0, ROW_NONE, '0},   // length one over the limit
    '{8'hAA, 1'b0, ROW_NONE, '0},
    '{8'hAA, 1'b1, ROW_NONE, '0},   // resync mid-frame, byte ignored
    '{8'h00, 1'b0, ROW_NONE, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [ByteW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  frx_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  frx_out_t            out_data_o;

  // Predictor copy of the configuration and receiver state.
  logic [ByteW-1:0]    cfg_sync;
  logic [ByteW-1:0]    cfg_cmd_type;
  logic [LenW-1:0]     cfg_limit;
  state_e              pr_phase;
  logic [15:0]         pr_len;
  logic [ByteW-1:0]    pr_type;
  logic [ByteW-1:0]    pr_seq;
  logic [LenW-1:0]     pr_count;
  logic [CrcW-1:0]     pr_crc;
  logic [ByteW-1:0]    pr_crc_lo;
  logic [ByteW-1:0]    pr_store [BufDepth];
  logic [ByteW-1:0]    pr_cmd_seq;

  frx_out_t            pending_results [$];

  bit                  steady;
  int unsigned         items_sent;
  int unsigned         resyncs_sent;
  int unsigned         frames_sent;
  int unsigned         settings_done;
  int unsigned         results_seen;
  int unsigned         naks_seen;
  int unsigned         fail_count;

  framed_packet_receiver_crc16 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Bit-serial CRC-16-CCITT, MSB first.
  function automatic logic [CrcW-1:0] crc_ccitt(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    logic fb;
    c = crc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = c[CrcW-1] ^ b[i];
      c = {c[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic int unsigned eff_limit();
    return (int'(cfg_limit) > BufDepth) ? BufDepth : int'(cfg_limit);
  endfunction

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic frx_in_t mk_in(input logic [ByteW-1:0] b, input logic rs);
    frx_in_t x;
    x.rx_byte = b;
    x.resync = rs;
    return x;
  endfunction

  function automatic frx_out_t frame_result(input logic kind, input logic [IndexW-1:0] idx,
                                            input logic [ByteW-1:0] data, input logic last);
    frx_out_t r;
    r.kind = kind;
    r.frame_type = pr_type;
    r.frame_seq = pr_seq;
    r.frame_length = pr_len[LenW-1:0];
    r.byte_index = idx;
    r.data_byte = data;
    r.last = last;
    r.command_seq = pr_cmd_seq;
    return r;
  endfunction

  // Advance the predicted receiver by one accepted item and queue its results.
  task automatic advance_receiver(input frx_in_t x, input bit keep);
    frx_out_t burst [$];
    int unsigned n;
    if (x.resync) begin
      pr_phase = ST_HUNT;
      pr_count = '0;
    end else begin
      case (pr_phase)
        ST_HUNT: begin
          if (x.rx_byte == cfg_sync) begin
            pr_phase = ST_LEN_LO;
            pr_count = '0;
            pr_crc = CrcInit;
          end
        end
        ST_LEN_LO: begin
          pr_len = {8'h00, x.rx_byte};
          pr_phase = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          pr_len[15:8] = x.rx_byte;
          pr_phase = (pr_len > eff_limit()) ? ST_HUNT : ST_TYPE;
        end
        ST_TYPE: begin
          pr_type = x.rx_byte;
          pr_crc = crc_ccitt(pr_crc, x.rx_byte);
          pr_phase = ST_SEQ;
        end
        ST_SEQ: begin
          pr_seq = x.rx_byte;
          pr_crc = crc_ccitt(pr_crc, x.rx_byte);
          pr_phase = (pr_len == 16'd0) ? ST_CRC_LO : ST_DATA;
        end
        ST_DATA: begin
          if (pr_count < BufDepth) pr_store[pr_count[IndexW-1:0]] = x.rx_byte;
          pr_crc = crc_ccitt(pr_crc, x.rx_byte);
          pr_count = pr_count + 7'd1;
          if (16'(pr_count) >= pr_len) pr_phase = ST_CRC_LO;
        end
        ST_CRC_LO: begin
          pr_crc_lo = x.rx_byte;
          pr_phase = ST_CRC_HI;
        end
        ST_CRC_HI: begin
          pr_phase = ST_HUNT;
          if ({x.rx_byte, pr_crc_lo} == pr_crc) begin
            n = (pr_len > BufDepth) ? BufDepth : int'(pr_len);
            if (pr_type == cfg_cmd_type) pr_cmd_seq = pr_seq;
            if (n == 0) begin
              burst.push_back(frame_result(KindGood, '0, '0, 1'b1));
            end else begin
              for (int unsigned i = 0; i < n; i++) begin
                burst.push_back(frame_result(KindGood, 6'(i), pr_store[i], i == n - 1));
              end
            end
          end else begin
            burst.push_back(frame_result(KindNak, '0, '0, 1'b1));
          end
        end
        default: begin
          pr_phase = ST_HUNT;
        end
      endcase
    end
    if (keep) begin
      foreach (burst[i]) pending_results.push_back(burst[i]);
    end
  endtask

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_byte(input frx_in_t x, input bit keep);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
    if (x.resync) resyncs_sent++;
    advance_receiver(x, keep);
  endtask

  // Stop offering input and let every queued result come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_SYNC:     cfg_sync = val;
      CFG_CMD_TYPE: cfg_cmd_type = val;
      CFG_LIMIT:    cfg_limit = val[LenW-1:0];
      default:      ;
    endcase
    settings_done++;
  endtask

  // Mostly short payloads, sometimes the limit, one over it, or a wild length.
  function automatic logic [15:0] pick_length();
    int unsigned eff;
    int unsigned r;
    eff = eff_limit();
    r = $urandom_range(0, 19);
    if (r == 0) return 16'(eff + 1);
    if (r == 1) return 16'($urandom_range(256, 65535));
    if (r <= 3) return 16'(eff);
    return 16'($urandom_range(0, (eff < 8) ? eff : 8));
  endfunction

  // One frame with random content; sometimes a bad CRC or a resync cut.
  task automatic send_frame(input logic [15:0] flen);
    logic [ByteW-1:0] fbytes [$];
    logic [ByteW-1:0] ftype;
    logic [ByteW-1:0] fseq;
    logic [ByteW-1:0] b;
    logic [CrcW-1:0]  crc;
    int               cut;
    ftype = ($urandom_range(0, 1) == 0) ? cfg_cmd_type : 8'($urandom);
    fseq = 8'($urandom);
    fbytes = '{cfg_sync, flen[7:0], flen[15:8]};
    if (flen <= eff_limit()) begin
      crc = crc_ccitt(CrcInit, ftype);
      crc = crc_ccitt(crc, fseq);
      fbytes.push_back(ftype);
      fbytes.push_back(fseq);
      repeat (flen) begin
        b = 8'($urandom);
        crc = crc_ccitt(crc, b);
        fbytes.push_back(b);
      end
      if ($urandom_range(0, 7) == 0) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      fbytes.push_back(crc[7:0]);
      fbytes.push_back(crc[15:8]);
    end
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, fbytes.size() - 1) : -1;
    foreach (fbytes[i]) begin
      if (i == cut) begin
        send_byte(mk_in(8'($urandom), 1'b1), 1'b1);
        break;
      end
      send_byte(mk_in(fbytes[i], 1'b0), 1'b1);
    end
    frames_sent++;
  endtask

  // Random frames with some noise in between, closed by a resync.
  task automatic run_frames(input int unsigned n, input bit first_max);
    int unsigned stop_at;
    bit big;
    logic [ByteW-1:0] b;
    stop_at = items_sent + n;
    big = first_max;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) steady = ~steady;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom);
          if (b == cfg_sync && $urandom_range(0, 3) != 0) b = ~b;
          send_byte(mk_in(b, $urandom_range(0, 5) == 0), 1'b1);
        end
      end
      send_frame(big ? 16'(eff_limit()) : pick_length());
      big = 1'b0;
    end
    send_byte(mk_in(8'($urandom), 1'b1), 1'b1);
  endtask

  // Result side: random stalls, every item compared with the oldest expectation.
  initial begin : result_side
    int unsigned gap;
    frx_out_t got;
    frx_out_t want;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = out_data_o;
      results_seen++;
      if (got.kind == KindNak) naks_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: kind=%0d type=%02h seq=%02h len=%0d idx=%0d",
                   got.kind, got.frame_type, got.frame_seq, got.frame_length,
                   got.byte_index);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.frame_type !== want.frame_type ||
            got.frame_seq !== want.frame_seq || got.frame_length !== want.frame_length ||
            got.byte_index !== want.byte_index || got.data_byte !== want.data_byte ||
            got.last !== want.last || got.command_seq !== want.command_seq) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch expected kind=%0d type=%02h seq=%02h len=%0d idx=%0d %s",
                     want.kind, want.frame_type, want.frame_seq, want.frame_length,
                     want.byte_index,
                     $sformatf("data=%02h last=%0d cmd=%02h",
                               want.data_byte, want.last, want.command_seq));
            $display("         actual   kind=%0d type=%02h seq=%02h len=%0d idx=%0d %s",
                     got.kind, got.frame_type, got.frame_seq, got.frame_length,
                     got.byte_index,
                     $sformatf("data=%02h last=%0d cmd=%02h",
                               got.data_byte, got.last, got.command_seq));
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases under several settings.
  initial begin : stimulus
    dir_row_t row;
    int unsigned w;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SYNC;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_sync = SyncReset;
    cfg_cmd_type = CmdTypeReset;
    cfg_limit = LimitReset;
    pr_phase = ST_HUNT;
    pr_len = '0;
    pr_type = '0;
    pr_seq = '0;
    pr_count = '0;
    pr_crc = CrcInit;
    pr_crc_lo = '0;
    pr_cmd_seq = '0;
    steady = 1'b0;
    items_sent = 0;
    resyncs_sent = 0;
    frames_sent = 0;
    settings_done = 1;
    results_seen = 0;
    naks_seen = 0;
    fail_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (DirRows[i]) begin
      row = DirRows[i];
      send_byte(mk_in(row.rx, row.rs), row.mode == ROW_MODEL);
      if (row.mode == ROW_ONE) pending_results.push_back(row.want);
    end
    settle();

    // Reset settings, opening with a full-size payload.
    run_frames(75, 1'b1);
    settle();

    // Lowest extremes: only empty payloads fit.
    write_reg(CFG_SYNC, 8'h00);
    write_reg(CFG_CMD_TYPE, 8'hFF);
    write_reg(CFG_LIMIT, 8'h00);
    run_frames(25, 1'b0);
    settle();

    // Highest extremes: the effective limit saturates at the buffer depth.
    write_reg(CFG_SYNC, 8'hFF);
    write_reg(CFG_CMD_TYPE, 8'h00);
    write_reg(CFG_LIMIT, 8'hFF);
    run_frames(50, 1'b1);
    settle();

    // Unused index is ignored, then random mid-range settings.
    write_reg(CfgIdxUnused, 8'($urandom));
    write_reg(CFG_SYNC, 8'($urandom));
    write_reg(CFG_CMD_TYPE, 8'($urandom));
    write_reg(CFG_LIMIT, 8'($urandom_range(1, 63)));
    run_frames(30, 1'b0);
    settle();

    // Back to the reset values.
    write_reg(CFG_SYNC, SyncReset);
    write_reg(CFG_CMD_TYPE, CmdTypeReset);
    write_reg(CFG_LIMIT, {1'b0, LimitReset});
    run_frames(25, 1'b0);

    // Drain with a bound; anything still queued is a failure.
    in_valid_i <= 1'b0;
    for (w = 0; w < DrainLimit && pending_results.size() != 0; w++) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      fail_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("Sent %0d items (%0d random frames, %0d resyncs) under %0d register settings.",
             items_sent, frames_sent, resyncs_sent, settings_done);
    $display("Checked %0d result items, %0d of them NAK requests; %0d failures.",
             results_seen, naks_seen, fail_count);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
